FILE: rtl/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared constants and types for the heightmap barycentric sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int MAX_ROW_VERTICES = 128;
  localparam int FRACTION_BITS = 16;
  localparam int GRID_DEPTH = MAX_ROW_VERTICES * MAX_ROW_VERTICES;
  localparam int ADDR_W = $clog2(GRID_DEPTH);
  localparam int IDX_W = $clog2(MAX_ROW_VERTICES) + 1;

  localparam logic [1:0] REG_TILE_SIZE = 2'd0;
  localparam logic [1:0] REG_ROW_VERTICES = 2'd1;
  localparam logic [1:0] REG_ORIGIN_X = 2'd2;
  localparam logic [1:0] REG_ORIGIN_Z = 2'd3;

  localparam logic FUNC_QUERY = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] world_x;
    logic [31:0] world_z;
    logic [7:0]  grid_x;
    logic [7:0]  grid_z;
    logic [31:0] new_height;
  } item_t;

  // divider request and response between the sequencer and the divider
  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

endpackage

FILE: rtl/hbs_divider.sv
// ----------------------------------------------------------------------------
// hbs_divider
// Restoring divider, one quotient bit per cycle, unsigned 48 by 32 bits.
// ----------------------------------------------------------------------------
module hbs_divider (
  input  logic              clk,
  input  logic              rst,
  input  hbs_pkg::div_req_t req,
  output hbs_pkg::div_rsp_t rsp
);
  import hbs_pkg::*;

  logic        busy;
  logic        done;
  logic [5:0]  count;
  logic [47:0] quo;
  logic [32:0] rem;
  logic [31:0] dsr;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem[31:0], quo[47]};
  assign trial = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= 6'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= 6'd48;
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= 33'd0;
      dsr <= req.divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial;
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[46:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;
  assign rsp.remainder = rem[31:0];

endmodule

FILE: rtl/hbs_grid_ram.sv
// ----------------------------------------------------------------------------
// hbs_grid_ram
// Height grid store, one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module hbs_grid_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [hbs_pkg::ADDR_W-1:0] addr,
  input  logic [31:0]                wdata,
  output logic [31:0]                rdata
);
  import hbs_pkg::*;

  logic [31:0] mem [GRID_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/heightmap_barycentric_sampler_unit.sv
// ----------------------------------------------------------------------------
// heightmap_barycentric_sampler_unit
// Height grid with triangle interpolation of a world point inside a tile.
// ----------------------------------------------------------------------------
// channel   dir  beat contents
// s_axis    in   one write or query item
// m_axis    out  one height per query, none per write
// cfg       in   tile size, row count, origin x and z
//
// a write goes through the write state back to idle; a query makes four passes of
// the shared divider (floor division and fraction for x, then z), a range
// check, four grid reads, two multiply steps and a round
// rst is synchronous and clears control only; the grid holds garbage until written
// s_axis_tready is low while an item is in work or its result waits on m_axis
module heightmap_barycentric_sampler_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tuser,   // func
  // world_x, world_z, grid_x, grid_z, new_height
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,   // terrain_height
  output logic [7:0]   m_axis_tuser,   // in_range
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import hbs_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_WRITE = 4'd1;
  localparam logic [3:0] ST_DIVX = 4'd2;
  localparam logic [3:0] ST_FRACX = 4'd3;
  localparam logic [3:0] ST_DIVZ = 4'd4;
  localparam logic [3:0] ST_FRACZ = 4'd5;
  localparam logic [3:0] ST_CHECK = 4'd6;
  localparam logic [3:0] ST_READ = 4'd7;
  localparam logic [3:0] ST_MUL1 = 4'd8;
  localparam logic [3:0] ST_MUL2 = 4'd9;
  localparam logic [3:0] ST_ROUND = 4'd10;
  localparam logic [3:0] ST_OUT = 4'd11;

  logic [31:0] tile_size;
  logic [7:0]  row_vertices;
  logic [31:0] origin_x;
  logic [31:0] origin_z;

  logic [3:0]  state;
  logic        wait_div;
  logic [2:0]  rd_cnt;
  item_t       item;
  logic [IDX_W-1:0] rv;

  logic signed [33:0] tx;
  logic signed [33:0] tz;
  logic [31:0] fx;
  logic [31:0] fz;
  logic [16:0] u;
  logic [16:0] v;
  logic signed [31:0] h00, h10, h01, h11;
  logic signed [50:0] prod_a;
  logic signed [50:0] prod_b;
  logic signed [52:0] acc;
  logic [31:0] out_height;
  logic        out_range;

  div_req_t dreq;
  div_rsp_t drsp;

  logic        ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [31:0] ram_rdata;

  hbs_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  hbs_grid_ram u_ram (.clk(clk), .we(ram_we), .addr(ram_addr),
                      .wdata(item.new_height), .rdata(ram_rdata));

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size <= 32'd65536;
      row_vertices <= 8'd128;
      origin_x <= 32'd0;
      origin_z <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TILE_SIZE: tile_size <= cfg_data;
        REG_ROW_VERTICES: row_vertices <= cfg_data[7:0];
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Z: origin_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rv = (row_vertices > 8'(MAX_ROW_VERTICES)) ? IDX_W'(MAX_ROW_VERTICES)
                                                    : IDX_W'(row_vertices);

  // signed differences and magnitudes for the floor division
  logic signed [32:0] rx, rz, rsel;
  logic [32:0] rmag;
  assign rx = 33'(signed'(item.world_x)) - 33'(signed'(origin_x));
  assign rz = 33'(signed'(item.world_z)) - 33'(signed'(origin_z));
  assign rsel = (state == ST_DIVX) ? rx : rz;
  assign rmag = rsel[32] ? 33'(-rsel) : 33'(rsel);

  // quotient and remainder turned into floor form
  logic signed [33:0] tq;
  logic [31:0] tr;
  always_comb begin
    if (!rsel[32]) begin
      tq = signed'(drsp.quotient[33:0]);
      tr = drsp.remainder;
    end else if (drsp.remainder == 32'd0) begin
      tq = -signed'(drsp.quotient[33:0]);
      tr = 32'd0;
    end else begin
      tq = -signed'(drsp.quotient[33:0]) - 34'sd1;
      tr = tile_size - drsp.remainder;
    end
  end

  always_comb begin
    dreq = '0;
    if (!wait_div) begin
      case (state)
        ST_DIVX, ST_DIVZ: begin
          dreq.start = 1'b1;
          dreq.dividend = {15'd0, rmag};
          dreq.divisor = tile_size;
        end
        ST_FRACX: begin
          dreq.start = 1'b1;
          dreq.dividend = {16'd0, fx} << FRACTION_BITS;
          dreq.divisor = tile_size;
        end
        ST_FRACZ: begin
          dreq.start = 1'b1;
          dreq.dividend = {16'd0, fz} << FRACTION_BITS;
          dreq.divisor = tile_size;
        end
        default: ;
      endcase
    end
  end

  // grid addresses
  logic [IDX_W-1:0] gx, gz, cx, cz;
  logic [2*IDX_W-1:0] lin;
  assign gx = IDX_W'(item.grid_x[6:0]);
  assign gz = IDX_W'(item.grid_z[6:0]);
  assign cx = IDX_W'(tx[IDX_W-1:0]) + IDX_W'(rd_cnt[0]);
  assign cz = IDX_W'(tz[IDX_W-1:0]) + IDX_W'(rd_cnt[1]);
  always_comb begin
    if (state == ST_WRITE) begin
      lin = (2*IDX_W)'(gx) + (2*IDX_W)'(gz) * (2*IDX_W)'(rv);
    end else begin
      lin = (2*IDX_W)'(cx) + (2*IDX_W)'(cz) * (2*IDX_W)'(rv);
    end
  end
  assign ram_addr = lin[ADDR_W-1:0];

  logic write_ok;
  assign write_ok = !item.grid_x[7] && !item.grid_z[7]
                    && (IDX_W'(item.grid_x[6:0]) < rv) && (IDX_W'(item.grid_z[6:0]) < rv);
  assign ram_we = (state == ST_WRITE) && write_ok;

  logic in_tile;
  assign in_tile = !tx[33] && !tz[33]
                   && (tx + 34'sd1 < 34'(rv)) && (tz + 34'sd1 < 34'(rv));

  logic upper;
  assign upper = (u <= v);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wait_div <= 1'b0;
      rd_cnt <= 3'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            wait_div <= 1'b0;
            if (s_axis_tuser[0] == FUNC_WRITE) begin
              state <= ST_WRITE;
            end else if (tile_size == 32'd0) begin
              out_height <= 32'd0;
              out_range <= 1'b0;
              state <= ST_OUT;
              m_axis_tvalid <= 1'b1;
            end else begin
              state <= ST_DIVX;
            end
          end
        end
        ST_WRITE: state <= ST_IDLE;
        ST_DIVX, ST_FRACX, ST_DIVZ, ST_FRACZ: begin
          if (!wait_div) begin
            wait_div <= 1'b1;
          end else if (drsp.done) begin
            wait_div <= 1'b0;
            case (state)
              ST_DIVX: begin tx <= tq; fx <= tr; state <= ST_FRACX; end
              ST_FRACX: begin u <= drsp.quotient[16:0]; state <= ST_DIVZ; end
              ST_DIVZ: begin tz <= tq; fz <= tr; state <= ST_FRACZ; end
              default: begin v <= drsp.quotient[16:0]; state <= ST_CHECK; end
            endcase
          end
        end
        ST_CHECK: begin
          rd_cnt <= 3'd0;
          if (in_tile) begin
            state <= ST_READ;
          end else begin
            out_height <= 32'd0;
            out_range <= 1'b0;
            state <= ST_OUT;
            m_axis_tvalid <= 1'b1;
          end
        end
        ST_READ: begin
          // address for corner rd_cnt is issued now, data lands next cycle
          rd_cnt <= rd_cnt + 3'd1;
          case (rd_cnt)
            3'd1: h00 <= ram_rdata;
            3'd2: h10 <= ram_rdata;
            3'd3: h01 <= ram_rdata;
            3'd4: h11 <= ram_rdata;
            default: ;
          endcase
          if (rd_cnt == 3'd4) state <= ST_MUL1;
        end
        ST_MUL1: begin
          if (upper) begin
            prod_a <= signed'({1'b0, v}) * (51'(h01) - 51'(h00));
            prod_b <= signed'({1'b0, u}) * (51'(h11) - 51'(h01));
          end else begin
            prod_a <= signed'({1'b0, u}) * (51'(h10) - 51'(h00));
            prod_b <= signed'({1'b0, v}) * (51'(h11) - 51'(h10));
          end
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          acc <= (53'(h00) <<< FRACTION_BITS) + 53'(prod_a) + 53'(prod_b)
                 + (53'sd1 <<< (FRACTION_BITS - 1));
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          if ((acc >>> FRACTION_BITS) > 53'sd2147483647) out_height <= 32'h7fffffff;
          else if ((acc >>> FRACTION_BITS) < -53'sd2147483648) out_height <= 32'h80000000;
          else out_height <= 32'(acc >>> FRACTION_BITS);
          out_range <= 1'b1;
          m_axis_tvalid <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      item.func <= s_axis_tuser[0];
      item.world_x <= s_axis_tdata[31:0];
      item.world_z <= s_axis_tdata[63:32];
      item.grid_x <= s_axis_tdata[71:64];
      item.grid_z <= s_axis_tdata[79:72];
      item.new_height <= s_axis_tdata[111:80];
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata = out_height;
  assign m_axis_tuser = {7'd0, out_range};

  a_out_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> state == ST_OUT) else $error("result shown outside output state");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tdata == 32'd0)
    else $error("out of range result not zero");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap sampler testbench
// Fills the height grid with write beats, then sends directed and random
// world-point queries under several tile sizes, row counts and origins.
// Every query result is checked field by field against a directed value or an
// in-bench interpolation predictor, with random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import hbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 250;
  localparam int RANDOM_ITEMS = 220;

  typedef struct {
    logic [31:0] height;
    logic        in_range;
  } height_result_t;

  typedef struct {
    logic        fn;
    logic [31:0] wx;
    logic [31:0] wz;
    logic [7:0]  gx;
    logic [7:0]  gz;
    logic [31:0] nh;
    bit          typed;
    logic [31:0] th;
    logic        ti;
  } stim_row_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tuser;
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic [7:0]   m_axis_tuser;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;

  heightmap_barycentric_sampler_unit uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [31:0] height_store [GRID_DEPTH];
  bit          height_written [GRID_DEPTH];
  logic [31:0] cur_tile;
  logic [7:0]  cur_rows;
  logic [31:0] cur_origin_x;
  logic [31:0] cur_origin_z;

  height_result_t pending_heights[$];
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint rows_used();
    return (cur_rows > MAX_ROW_VERTICES) ? MAX_ROW_VERTICES : longint'(cur_rows);
  endfunction

  // returns 1 when the query would read a grid entry never written
  function automatic bit sample_terrain(input logic [31:0] wx, input logic [31:0] wz,
                                        output logic [31:0] h, output logic inr);
    longint t, rv, rx, rz, tx, tz, fx, fz, u, v, acc, hh;
    longint h00, h10, h01, h11;
    int a00, a10, a01, a11;
    h = '0;
    inr = 1'b0;
    rv = rows_used();
    t = longint'(cur_tile);
    if (t == 0) return 0;
    rx = longint'($signed(wx)) - longint'($signed(cur_origin_x));
    rz = longint'($signed(wz)) - longint'($signed(cur_origin_z));
    tx = rx / t; fx = rx % t;
    tz = rz / t; fz = rz % t;
    if (fx < 0) begin fx += t; tx -= 1; end
    if (fz < 0) begin fz += t; tz -= 1; end
    if (tx < 0 || tx + 1 >= rv || tz < 0 || tz + 1 >= rv) return 0;
    u = (fx << FRACTION_BITS) / t;
    v = (fz << FRACTION_BITS) / t;
    a00 = int'(tx + tz * rv);
    a10 = a00 + 1;
    a01 = int'(tx + (tz + 1) * rv);
    a11 = a01 + 1;
    if (!height_written[a00] || !height_written[a10] ||
        !height_written[a01] || !height_written[a11]) return 1;
    h00 = longint'($signed(height_store[a00]));
    h10 = longint'($signed(height_store[a10]));
    h01 = longint'($signed(height_store[a01]));
    h11 = longint'($signed(height_store[a11]));
    acc = h00 <<< FRACTION_BITS;
    if (u <= v) acc += v * (h01 - h00) + u * (h11 - h01);
    else acc += u * (h10 - h00) + v * (h11 - h10);
    acc += longint'(1) <<< (FRACTION_BITS - 1);
    hh = acc >>> FRACTION_BITS;
    if (hh > 64'sd2147483647) hh = 64'sd2147483647;
    if (hh < -64'sd2147483648) hh = -64'sd2147483648;
    h = hh[31:0];
    inr = 1'b1;
    return 0;
  endfunction

  task automatic send_item(input stim_row_t r);
    height_result_t res;
    longint gx, gz, rv;
    gx = longint'($signed(r.gx));
    gz = longint'($signed(r.gz));
    rv = rows_used();
    if (r.fn == FUNC_WRITE) begin
      if (gx >= 0 && gz >= 0 && gx < rv && gz < rv) begin
        height_store[gx + gz * rv] = r.nh;
        height_written[gx + gz * rv] = 1'b1;
      end
    end else begin
      void'(sample_terrain(r.wx, r.wz, res.height, res.in_range));
      if (r.typed) begin
        res.height = r.th;
        res.in_range = r.ti;
      end
    end
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= {7'd0, r.fn};
    s_axis_tdata <= {r.nh, r.gz, r.gx, r.wz, r.wx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (r.fn == FUNC_QUERY) pending_heights.push_back(res);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] ts, input logic [7:0] rv,
                            input logic [31:0] ox, input logic [31:0] oz);
    wait_drained();
    // a write beat may still be in work with no result to show for it
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_TILE_SIZE; cfg_data <= ts;
    @(posedge clk);
    cfg_index <= REG_ROW_VERTICES; cfg_data <= {24'd0, rv};
    @(posedge clk);
    cfg_index <= REG_ORIGIN_X; cfg_data <= ox;
    @(posedge clk);
    cfg_index <= REG_ORIGIN_Z; cfg_data <= oz;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_tile = ts; cur_rows = rv; cur_origin_x = ox; cur_origin_z = oz;
  endtask

  function automatic logic [31:0] random_height();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t write_row(input longint gx, input longint gz);
    stim_row_t r;
    r = '{FUNC_WRITE, $urandom, $urandom, gx[7:0], gz[7:0], random_height(), 0, 0, 0};
    return r;
  endfunction

  task automatic fill_grid();
    longint rv;
    longint xs[$];
    rv = rows_used();
    if (rv <= 10) begin
      for (longint i = 0; i < rv; i++) xs.push_back(i);
    end else begin
      for (longint i = 0; i < 5; i++) xs.push_back(i);
      for (longint i = rv - 5; i < rv; i++) xs.push_back(i);
    end
    foreach (xs[i]) foreach (xs[j]) send_item(write_row(xs[i], xs[j]));
  endtask

  function automatic longint pick_tile();
    longint rv;
    rv = rows_used();
    if (rv <= 10) return $urandom_range(0, rv - 2);
    if ($urandom_range(1)) return $urandom_range(0, 3);
    return rv - 5 + $urandom_range(0, 3);
  endfunction

  function automatic longint pick_offset();
    longint t;
    t = longint'(cur_tile);
    case ($urandom_range(5))
      0: return 0;
      1: return t - 1;
      default: return longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % t;
    endcase
  endfunction

  task automatic random_query();
    stim_row_t r;
    logic [31:0] h;
    logic inr;
    longint wxl, wzl;
    bit bad;
    r = '{FUNC_QUERY, 0, 0, $urandom, $urandom, $urandom, 0, 0, 0};
    bad = 1;
    while (bad) begin
      r.wx = $urandom;
      r.wz = $urandom;
      if ($urandom_range(9) < 7) begin
        wxl = longint'($signed(cur_origin_x)) + pick_tile() * longint'(cur_tile)
              + pick_offset();
        wzl = longint'($signed(cur_origin_z)) + pick_tile() * longint'(cur_tile)
              + pick_offset();
        if (wxl >= -64'sd2147483648 && wxl <= 64'sd2147483647) r.wx = wxl[31:0];
        if (wzl >= -64'sd2147483648 && wzl <= 64'sd2147483647) r.wz = wzl[31:0];
      end
      bad = sample_terrain(r.wx, r.wz, h, inr);
    end
    send_item(r);
  endtask

  // result side: random stalls and checking
  always @(posedge clk) begin
    height_result_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_heights.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: height %h in_range %b",
                     m_axis_tdata, m_axis_tuser[0]);
        end else begin
          e = pending_heights.pop_front();
          if (m_axis_tdata !== e.height || m_axis_tuser[0] !== e.in_range) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected height %h in_range %b, got %h %b",
                       e.height, e.in_range, m_axis_tdata, m_axis_tuser[0]);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t directed [$];
    logic [31:0] phase_tile [6];
    logic [7:0]  phase_rows [6];
    logic [31:0] phase_ox [6];
    logic [31:0] phase_oz [6];
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = '0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_TILE_SIZE;
    cfg_data = '0;
    send_idle_pct = 10;
    recv_stall_pct = 50;
    cur_tile = 32'h0001_0000; cur_rows = 8'd128; cur_origin_x = '0; cur_origin_z = '0;
    foreach (height_written[i]) height_written[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: unit tiles, full grid, origin at zero
    directed = '{
      '{FUNC_WRITE, 0, 0, 8'd0,   8'd0,   32'h7FFF_FFFF, 0, 0, 0},
      '{FUNC_WRITE, 0, 0, 8'd1,   8'd0,   32'h8000_0000, 0, 0, 0},
      '{FUNC_WRITE, 0, 0, 8'd0,   8'd1,   32'h0000_0000, 0, 0, 0},
      '{FUNC_WRITE, 0, 0, 8'd1,   8'd1,   32'h1234_5678, 0, 0, 0},
      '{FUNC_WRITE, 0, 0, 8'd127, 8'd127, 32'h0001_0000, 0, 0, 0},
      '{FUNC_WRITE, 0, 0, 8'd126, 8'd127, 32'h0002_0000, 0, 0, 0},
      '{FUNC_WRITE, 0, 0, 8'd127, 8'd126, 32'h0003_0000, 0, 0, 0},
      '{FUNC_WRITE, 0, 0, 8'd126, 8'd126, 32'hFFFF_0000, 0, 0, 0},
      // ignored writes outside the grid
      '{FUNC_WRITE, 0, 0, 8'hFF,  8'd0,   32'h5555_5555, 0, 0, 0},
      '{FUNC_WRITE, 0, 0, 8'd0,   8'h80,  32'hAAAA_AAAA, 0, 0, 0},
      '{FUNC_WRITE, 0, 0, 8'd128 - 8'd0, 8'd5, 32'hAAAA_AAAA, 0, 0, 0},
      // tile corner, exactly h00, then points inside tiles
      '{FUNC_QUERY, 32'h0, 32'h0, 0, 0, 0, 1, 32'h7FFF_FFFF, 1'b1},
      '{FUNC_QUERY, 32'h0, 32'h0000_FFFF, 0, 0, 0, 0, 0, 0},
      '{FUNC_QUERY, 32'h0000_FFFF, 32'h0, 0, 0, 0, 0, 0, 0},
      '{FUNC_QUERY, 32'h0000_8000, 32'h0000_8000, 0, 0, 0, 0, 0, 0},
      '{FUNC_QUERY, 32'h0000_FFFF, 32'h0000_FFFF, 0, 0, 0, 0, 0, 0},
      '{FUNC_QUERY, 32'h007E_FFFF, 32'h007E_0001, 0, 0, 0, 0, 0, 0},
      // outside the grid on every side
      '{FUNC_QUERY, 32'hFFFF_FFFF, 32'h0, 0, 0, 0, 1, 32'h0, 1'b0},
      '{FUNC_QUERY, 32'h0, 32'h8000_0000, 0, 0, 0, 1, 32'h0, 1'b0},
      '{FUNC_QUERY, 32'h007F_0000, 32'h0, 0, 0, 0, 1, 32'h0, 1'b0},
      '{FUNC_QUERY, 32'h0, 32'h7FFF_FFFF, 0, 0, 0, 1, 32'h0, 1'b0}
    };
    foreach (directed[i]) send_item(directed[i]);

    phase_tile = '{32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                   32'h0003_0000, 32'h0000_8000, $urandom_range(1, 32'h0010_0000)};
    phase_rows = '{8'd4, 8'd2, 8'd3, 8'd255, 8'd128, $urandom_range(2, 10)};
    phase_ox = '{32'h0, 32'h8000_0000, 32'h8000_0000, 32'hFF9C_0000, 32'h7FFF_0000,
                 $urandom};
    phase_oz = '{32'h0, 32'h7FFF_FFF0, 32'h8000_0000, 32'h0032_0000, 32'h0,
                 $urandom_range(0, 32'h00FF_FFFF)};

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 10 : (p < 4) ? 50 : 0;
      set_config(phase_tile[p], phase_rows[p], phase_ox[p], phase_oz[p]);
      recv_stall_pct = (p < 2) ? 50 : (p < 4) ? 10 : 0;
      fill_grid();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if (p == 3 && n == RANDOM_ITEMS / 2) wait_drained();
        if ($urandom_range(99) < 15) send_item(write_row($urandom, $urandom));
        else random_query();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
